/* rtl/core/step_sequencer_track_clock_assert.svh */
// Assertion macros for the step sequencer track clock checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef STEP_SEQUENCER_TRACK_CLOCK_ASSERT_SVH
`define STEP_SEQUENCER_TRACK_CLOCK_ASSERT_SVH

// clocked property, switched off while reset is held
`define SSTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked property that also holds through reset
`define SSTC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

/* rtl/core/sstc_pkg.sv */
// Shared types and constants for the step sequencer track clock.
// No dependencies; imported by every module of the block but sstc_ram.
`timescale 1ns / 1ps

package sstc_pkg;

    localparam int MAX_STEPS_DEF = 64;
    localparam int MAX_TPS_DEF   = 16;

    localparam int ACTION_W     = 3;
    localparam int VALUE_W      = 7;
    localparam int STEP_COUNT_W = 7;
    localparam int OUT_STEP_W   = 6;
    localparam int PHASE_W      = 2;
    // step count plus length extension
    localparam int LEN_W        = 8;
    // wide enough for any step index or MAX_STEPS itself
    localparam int IDX_W        = 9;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int STEP_COUNT_RESET = 16;
    localparam int TPS_RESET        = 4;

    // register indexes, word addressed
    localparam logic [1:0] REG_STEP_COUNT = 2'd0;
    localparam logic [1:0] REG_TRIG_EN    = 2'd1;
    localparam logic [1:0] REG_PLAYING    = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK        = 3'd0,
        ACT_SCHED_TEMPO = 3'd1,
        ACT_SET_TEMPO   = 3'd2,
        ACT_ADJUST      = 3'd3,
        ACT_EXTEND      = 3'd4,
        ACT_REWIND      = 3'd5,
        ACT_MUTE        = 3'd6,
        ACT_TOGGLE      = 3'd7
    } t_action;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/core/step_sequencer_track_clock.sv */
// One track of a step sequencer clock: tick and control requests in, one result out each.
// A tick that ends a step goes through fire, divide and finish states, the divide state waiting
// on the bit-serial remainder unit that wraps the position (one bit per cycle); a step toggle
// goes through toggle and finish, a step end on an empty loop through fire and finish, and any
// other request straight to finish. A stalled result waits in finish. The block takes one
// request at a time and holds off input while busy. Step active bits live in a RAM with a valid
// flag per step, so no clearing pass is needed. Depends on sstc_pkg, sstc_ram and sstc_remdiv.
`timescale 1ns / 1ps

module step_sequencer_track_clock #(
    parameter int MAX_STEPS = sstc_pkg::MAX_STEPS_DEF,
    parameter int MAX_TPS   = sstc_pkg::MAX_TPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sstc_pkg::ACTION_W-1:0]     i_action,
    input  logic [sstc_pkg::VALUE_W-1:0]      i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_trigger_fired,
    output logic [sstc_pkg::OUT_STEP_W-1:0]   o_trigger_step,
    output logic [sstc_pkg::OUT_STEP_W-1:0]   o_position,
    output logic [sstc_pkg::PHASE_W-1:0]      o_phase,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sstc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sstc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sstc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import sstc_pkg::*;

    localparam int POS_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int TPS_MAX = (MAX_TPS > TPS_RESET) ? MAX_TPS : TPS_RESET;
    localparam int TPS_W   = $clog2(TPS_MAX + 1);
    localparam int DVD_W   = POS_W + 1;

    localparam logic [VALUE_W-1:0] MAX_TPS_V   = VALUE_W'(MAX_TPS);
    localparam logic [IDX_W-1:0]   MAX_STEPS_X = IDX_W'(MAX_STEPS);
    localparam logic [TPS_W-1:0]   TPS_RST     = TPS_W'(TPS_RESET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIRE,
        ST_DIV,
        ST_TOG,
        ST_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [STEP_COUNT_W-1:0] r_step_count;
    logic                    r_trig_en;
    logic                    r_playing;

    // track state
    logic [TPS_W-1:0]   r_elapsed;
    logic [PHASE_W-1:0] r_phase;
    logic [POS_W-1:0]   r_pos;
    logic [TPS_W-1:0]   r_eff;
    logic [TPS_W-1:0]   r_base;
    logic [TPS_W-1:0]   r_pending;
    logic               r_rewind;
    logic [VALUE_W-1:0] r_ext;
    logic               r_muted;
    logic [MAX_STEPS-1:0] r_valid;

    // request and result
    t_action            r_action;
    logic [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]   r_idx;
    logic               r_fired;
    logic [POS_W-1:0]   r_fired_step;
    logic               r_out_valid;
    logic               r_out_fired;
    logic [OUT_STEP_W-1:0] r_out_step;
    logic [OUT_STEP_W-1:0] r_out_pos;
    logic [PHASE_W-1:0] r_out_phase;

    // tick look-ahead
    logic [PHASE_W-1:0] n_phase;
    logic [TPS_W-1:0]   n_el_inc;
    logic               n_rew;
    logic               n_pend;
    logic [TPS_W-1:0]   n_elapsed;
    logic [POS_W-1:0]   n_pos;
    logic [TPS_W-1:0]   n_eff;
    logic               n_step_end;

    logic [IDX_W-1:0]   v_ext;
    logic [VALUE_W-1:0] v_sat;
    logic [VALUE_W-1:0] v_clamp;
    logic               v_in_range;
    logic               v_idx_ok;

    logic [LEN_W-1:0]   len;
    logic [DVD_W-1:0]   dividend;
    logic               ram_rdata;
    logic               ram_we;
    logic               ram_wdata;
    logic [POS_W-1:0]   ram_raddr;
    logic               cur_active;
    logic               tog_bit;

    logic               div_start;
    t_div_stat          div_stat;
    logic [LEN_W-1:0]   div_rem;
    logic [IDX_W-1:0]   rem_x;
    logic [POS_W-1:0]   wrap_pos;

    logic               cfg_wr;
    logic [IDX_W-1:0]   out_step_x;
    logic [IDX_W-1:0]   out_pos_x;

    always_comb begin
        n_phase    = r_phase + PHASE_W'(1);
        n_el_inc   = r_elapsed + TPS_W'(1);
        n_rew      = r_rewind && (n_phase == '0);
        n_pend     = (r_pending != '0) && (n_phase == '0);
        n_elapsed  = (n_rew || n_pend) ? '0 : n_el_inc;
        n_pos      = (n_rew || n_pend) ? '0 : r_pos;
        n_eff      = n_pend ? r_pending : r_eff;
        n_step_end = (n_elapsed >= n_eff);
    end

    always_comb begin
        v_ext      = IDX_W'(r_value);
        v_sat      = (r_value > MAX_TPS_V) ? MAX_TPS_V : r_value;
        v_clamp    = (r_value == '0) ? VALUE_W'(1) : v_sat;
        v_in_range = (r_value != '0) && (r_value <= MAX_TPS_V);
        v_idx_ok   = (v_ext < MAX_STEPS_X);
    end

    assign len        = LEN_W'(r_step_count) + LEN_W'(r_ext);
    assign dividend   = DVD_W'(r_pos) + DVD_W'(1);
    assign div_start  = (r_state == ST_FIRE) && (len != '0);
    assign rem_x      = IDX_W'(div_rem);
    assign wrap_pos   = (rem_x >= MAX_STEPS_X) ? '0 : div_rem[POS_W-1:0];

    // a step never written reads as active
    assign cur_active = r_valid[r_pos] ? ram_rdata : 1'b1;
    assign tog_bit    = r_valid[r_idx] ? ram_rdata : 1'b1;
    assign ram_raddr  = (r_action == ACT_TOGGLE) ? v_ext[POS_W-1:0] : n_pos;
    assign ram_we     = (r_state == ST_TOG);
    assign ram_wdata  = ~tog_bit;

    sstc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_STEPS),
        .AW    (POS_W)
    ) u_active_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sstc_remdiv #(
        .DVD_W (DVD_W)
    ) u_remdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (len),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step_count <= STEP_COUNT_W'(STEP_COUNT_RESET);
            r_trig_en    <= 1'b1;
            r_playing    <= 1'b1;
            r_elapsed    <= '0;
            r_phase      <= '0;
            r_pos        <= '0;
            r_eff        <= TPS_RST;
            r_base       <= TPS_RST;
            r_pending    <= '0;
            r_rewind     <= 1'b0;
            r_ext        <= '0;
            r_muted      <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_STEP_COUNT: r_step_count <= pwdata[STEP_COUNT_W-1:0];
                    REG_TRIG_EN:    r_trig_en    <= pwdata[0];
                    REG_PLAYING:    r_playing    <= pwdata[0];
                    default: ;
                endcase
            end

            // drop a taken result unless the finishing state reloads it this cycle
            if (r_out_valid && !i_out_stall && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= t_action'(i_action);
                        r_value  <= i_value;
                        r_state  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_fired      <= 1'b0;
                    r_fired_step <= '0;
                    if ((r_action == ACT_TICK) && r_playing && n_step_end) begin
                        r_state <= ST_FIRE;
                    end else if ((r_action == ACT_TOGGLE) && v_idx_ok) begin
                        r_state <= ST_TOG;
                    end else begin
                        r_state <= ST_FIN;
                    end
                    case (r_action)
                        ACT_TICK: begin
                            if (r_playing) begin
                                r_phase <= n_phase;
                                r_pos   <= n_pos;
                                r_eff   <= n_eff;
                                if (n_rew) begin
                                    r_rewind <= 1'b0;
                                end
                                if (n_pend) begin
                                    r_base    <= r_pending;
                                    r_ext     <= '0;
                                    r_pending <= '0;
                                end
                                if (n_step_end) begin
                                    r_elapsed <= '0;
                                end else begin
                                    r_elapsed <= n_elapsed;
                                end
                            end
                        end
                        ACT_SCHED_TEMPO: r_pending <= v_sat[TPS_W-1:0];
                        ACT_SET_TEMPO: begin
                            r_base    <= v_clamp[TPS_W-1:0];
                            r_elapsed <= '0;
                        end
                        ACT_ADJUST: begin
                            if (v_in_range) begin
                                r_eff <= r_value[TPS_W-1:0];
                            end
                        end
                        ACT_EXTEND: r_ext    <= r_value;
                        ACT_REWIND: r_rewind <= 1'b1;
                        ACT_MUTE:   r_muted  <= ~r_muted;
                        ACT_TOGGLE: r_idx    <= v_ext[POS_W-1:0];
                        default: ;
                    endcase
                end
                ST_FIRE: begin
                    if (r_trig_en && !r_muted && cur_active) begin
                        r_fired      <= 1'b1;
                        r_fired_step <= r_pos;
                    end
                    if (len == '0) begin
                        // empty loop: park at step zero and fall back to base
                        r_pos   <= '0;
                        r_ext   <= '0;
                        r_eff   <= r_base;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        r_pos <= wrap_pos;
                        if (wrap_pos == '0) begin
                            r_ext     <= '0;
                            r_eff     <= r_base;
                            r_elapsed <= '0;
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_TOG: begin
                    r_valid[r_idx] <= 1'b1;
                    r_state        <= ST_FIN;
                end
                ST_FIN: begin
                    // hold the result until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_fired <= r_fired;
                        r_out_step  <= out_step_x[OUT_STEP_W-1:0];
                        r_out_pos   <= out_pos_x[OUT_STEP_W-1:0];
                        r_out_phase <= r_phase;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign out_step_x = IDX_W'(r_fired_step);
    assign out_pos_x  = IDX_W'(r_pos);

    always_comb begin
        case (paddr[3:2])
            REG_STEP_COUNT: prdata = APB_DATA_W'(r_step_count);
            REG_TRIG_EN:    prdata = APB_DATA_W'(r_trig_en);
            REG_PLAYING:    prdata = APB_DATA_W'(r_playing);
            default:        prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_trigger_fired = r_out_fired;
    assign o_trigger_step  = r_out_step;
    assign o_position      = r_out_pos;
    assign o_phase         = r_out_phase;

endmodule

/* rtl/core/sstc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module sstc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sstc_remdiv.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on sstc_pkg for the divisor width and the status struct.
`timescale 1ns / 1ps

module sstc_remdiv #(
    parameter int DVD_W = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DVD_W-1:0]         i_dividend,
    input  logic [sstc_pkg::LEN_W-1:0] i_divisor,
    output sstc_pkg::t_div_stat      o_stat,
    output logic [sstc_pkg::LEN_W-1:0] o_rem
);
    import sstc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [LEN_W-1:0] r_dvs;
    logic [LEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [LEN_W:0]   n_trial;
    logic [LEN_W:0]   n_diff;
    logic [LEN_W-1:0] n_rem;

    // remainder stays below the divisor, so one subtract per bit suffices
    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_rem = n_diff[LEN_W-1:0];
        end else begin
            n_rem = n_trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

/* rtl/core/sstc_checker.sv */
// Port-level checks for the step sequencer track clock, bound to the top level.
// Depends on sstc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "step_sequencer_track_clock_assert.svh"

module sstc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_trigger_fired,
    input logic [sstc_pkg::OUT_STEP_W-1:0] o_trigger_step,
    input logic [sstc_pkg::OUT_STEP_W-1:0] o_position,
    input logic [sstc_pkg::PHASE_W-1:0]    o_phase
);
    import sstc_pkg::*;

    // busy for at least the cycle after a request is taken
    `SSTC_ASSERT(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "input not held off after request")

    // no result can appear the cycle after a request is taken
    `SSTC_ASSERT(a_min_latency, i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid, "result too early")

    // stalled result holds
    `SSTC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_position) && $stable(o_phase) && $stable(o_trigger_step) && $stable(o_trigger_fired), "stalled result changed")

    // reset leaves the block empty and ready
    `SSTC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "not empty after reset")

endmodule

bind step_sequencer_track_clock sstc_checker u_sstc_checker (.*);

/* test/track_clock_checker.sv */
// Checker for the step sequencer track clock: watches the request, result and register
// channels, keeps its own copy of the track state and compares every result in order.
// Depends on sstc_pkg.
`timescale 1ns / 1ps

module track_clock_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [sstc_pkg::ACTION_W-1:0]   i_action,
    input  logic [sstc_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_trigger_fired,
    input  logic [sstc_pkg::OUT_STEP_W-1:0] i_trigger_step,
    input  logic [sstc_pkg::OUT_STEP_W-1:0] i_position,
    input  logic [sstc_pkg::PHASE_W-1:0]    i_phase,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [sstc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [sstc_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                              o_errors,
    output int                              o_outstanding
);
    import sstc_pkg::*;

    localparam int MAX_STEPS = MAX_STEPS_DEF;
    localparam int MAX_TPS   = MAX_TPS_DEF;

    typedef struct packed {
        logic                  fired;
        logic [OUT_STEP_W-1:0] trig_step;
        logic [OUT_STEP_W-1:0] position;
        logic [PHASE_W-1:0]    phase;
    } t_track_result;

    t_track_result expected_results[$];
    t_track_result oldest;
    t_track_result predicted;
    int mismatches  = 0;
    int outstanding = 0;

    // register copies
    int   loop_steps;
    logic trig_en;
    logic playing;

    // track state
    int               elapsed;
    int               tick_phase;
    int               position;
    int               eff_tps;
    int               base_tps;
    int               pend_tps;
    int               ext_len;
    logic             rewind_req;
    logic             muted;
    logic [MAX_STEPS-1:0] step_on;

    assign o_errors      = mismatches;
    assign o_outstanding = outstanding;

    function automatic void reset_track();
        loop_steps = STEP_COUNT_RESET;
        trig_en    = 1'b1;
        playing    = 1'b1;
        elapsed    = 0;
        tick_phase = 0;
        position   = 0;
        eff_tps    = TPS_RESET;
        base_tps   = TPS_RESET;
        pend_tps   = 0;
        ext_len    = 0;
        rewind_req = 1'b0;
        muted      = 1'b0;
        step_on    = '1;
    endfunction

    function automatic void restore_base();
        ext_len = 0;
        eff_tps = base_tps;
        elapsed = 0;
    endfunction

    function automatic t_track_result advance_track(t_action act, int val);
        t_track_result res;
        int loop_len;
        res = '0;
        case (act)
            ACT_TICK: begin
                if (playing) begin
                    if (elapsed < 255) elapsed++;
                    tick_phase = (tick_phase + 1) % 4;
                    if (rewind_req && tick_phase == 0) begin
                        elapsed    = 0;
                        position   = 0;
                        rewind_req = 1'b0;
                    end
                    // scheduled tempo lands on the phase boundary and restarts the loop
                    if (pend_tps > 0 && tick_phase == 0) begin
                        base_tps = pend_tps;
                        position = 0;
                        restore_base();
                        pend_tps = 0;
                    end
                    if (elapsed >= eff_tps) begin
                        loop_len = loop_steps + ext_len;
                        elapsed  = 0;
                        if (trig_en && !muted && position < MAX_STEPS && step_on[position]) begin
                            res.fired     = 1'b1;
                            res.trig_step = position[OUT_STEP_W-1:0];
                        end
                        if (loop_len < 1) position = 0;
                        else position = (position + 1) % loop_len;
                        if (position >= MAX_STEPS) position = 0;
                        if (position == 0) restore_base();
                    end
                end
            end
            ACT_SCHED_TEMPO: pend_tps = (val > MAX_TPS) ? MAX_TPS : val;
            ACT_SET_TEMPO: begin
                base_tps = (val < 1) ? 1 : ((val > MAX_TPS) ? MAX_TPS : val);
                elapsed  = 0;
            end
            ACT_ADJUST: begin
                if (val >= 1 && val <= MAX_TPS) eff_tps = val;
            end
            ACT_EXTEND: ext_len = val;
            ACT_REWIND: rewind_req = 1'b1;
            ACT_MUTE:   muted = !muted;
            ACT_TOGGLE: begin
                if (val < MAX_STEPS) step_on[val] = !step_on[val];
            end
            default: ;
        endcase
        res.position = position[OUT_STEP_W-1:0];
        res.phase    = tick_phase[PHASE_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_track();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_STEP_COUNT: loop_steps = int'(i_pwdata[STEP_COUNT_W-1:0]);
                    REG_TRIG_EN:    trig_en    = i_pwdata[0];
                    REG_PLAYING:    playing    = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predicted        = advance_track(t_action'(i_action), int'(i_value));
                expected_results = {expected_results, predicted};
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none actual pos %0d",
                             $time, i_position);
                    mismatches++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("trigger_fired", oldest.fired, i_trigger_fired);
                    check_field("trigger_step", oldest.trig_step, i_trigger_step);
                    check_field("position", oldest.position, i_position);
                    check_field("phase", oldest.phase, i_phase);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

/* test/tb_step_sequencer_track_clock.sv */
// Testbench top for the step sequencer track clock: clock, reset, register writes and
// request stimulus with varied idling; the verdict comes from track_clock_checker.
// Depends on sstc_pkg, step_sequencer_track_clock and track_clock_checker.
`timescale 1ns / 1ps

module tb_step_sequencer_track_clock;
    import sstc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int END_WAIT    = 40;
    localparam int IDLE_HEAVY  = 59;
    localparam int IDLE_LIGHT  = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [ACTION_W-1:0]   in_action = '0;
    logic [VALUE_W-1:0]    in_value  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  trigger_fired;
    logic [OUT_STEP_W-1:0] trigger_step;
    logic [OUT_STEP_W-1:0] position;
    logic [PHASE_W-1:0]    phase;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    step_sequencer_track_clock dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (in_action),
        .i_value         (in_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_trigger_fired (trigger_fired),
        .o_trigger_step  (trigger_step),
        .o_position      (position),
        .o_phase         (phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    track_clock_checker track_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_action        (in_action),
        .i_value         (in_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_trigger_fired (trigger_fired),
        .i_trigger_step  (trigger_step),
        .i_position      (position),
        .i_phase         (phase),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_errors        (errors),
        .o_outstanding   (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_step_sequencer_track_clock: done, errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_request(input t_action act, input logic [VALUE_W-1:0] val);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_value  <= val;
        do @(posedge clk); while (in_stall);
    endtask

    // hold off new requests until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int steps, input logic trig, input logic play);
        write_reg(REG_STEP_COUNT, APB_DATA_W'(steps));
        write_reg(REG_TRIG_EN, APB_DATA_W'(trig));
        write_reg(REG_PLAYING, APB_DATA_W'(play));
    endtask

    task automatic play_random(input int count);
        t_action              act;
        logic [VALUE_W-1:0]   val;
        int                   pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)      act = ACT_TICK;
            else if (pick < 80) act = ACT_SCHED_TEMPO;
            else if (pick < 83) act = ACT_SET_TEMPO;
            else if (pick < 87) act = ACT_ADJUST;
            else if (pick < 91) act = ACT_EXTEND;
            else if (pick < 93) act = ACT_REWIND;
            else if (pick < 95) act = ACT_MUTE;
            else                act = ACT_TOGGLE;
            val = VALUE_W'($urandom_range(0, 127));
            // keep most control values in the useful range
            if ($urandom_range(0, 99) < 80) begin
                case (act)
                    ACT_SCHED_TEMPO, ACT_SET_TEMPO, ACT_ADJUST:
                        val = VALUE_W'($urandom_range(0, 18));
                    ACT_EXTEND: val = VALUE_W'($urandom_range(0, 8));
                    ACT_TOGGLE: val = VALUE_W'($urandom_range(0, 63));
                    default: ;
                endcase
            end
            if ($urandom_range(0, 99) == 0) wait_drained();
            send_request(act, val);
        end
    endtask

    initial begin
        int   steps;
        logic trig;
        logic play;
        int   count;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(STEP_COUNT_RESET, 1'b1, 1'b1);

        // directed: tempo limits, step toggles, mute, extension, rewind
        send_request(ACT_ADJUST, 7'd0);
        send_request(ACT_ADJUST, 7'd17);
        send_request(ACT_ADJUST, 7'd1);
        send_request(ACT_TICK, 7'd127);
        send_request(ACT_TICK, 7'd0);
        send_request(ACT_TOGGLE, 7'd2);
        send_request(ACT_TICK, 7'd0);
        send_request(ACT_TOGGLE, 7'd64);
        send_request(ACT_TOGGLE, 7'd127);
        send_request(ACT_TOGGLE, 7'd63);
        send_request(ACT_MUTE, 7'd0);
        send_request(ACT_TICK, 7'd0);
        send_request(ACT_MUTE, 7'd127);
        send_request(ACT_SET_TEMPO, 7'd127);
        send_request(ACT_SET_TEMPO, 7'd0);
        send_request(ACT_EXTEND, 7'd127);
        send_request(ACT_EXTEND, 7'd0);
        send_request(ACT_SCHED_TEMPO, 7'd127);
        send_request(ACT_SCHED_TEMPO, 7'd0);
        send_request(ACT_SCHED_TEMPO, 7'd3);
        send_request(ACT_REWIND, 7'd0);
        repeat (4) send_request(ACT_TICK, 7'd0);
        send_request(ACT_ADJUST, 7'd16);
        send_request(ACT_TICK, 7'd0);

        for (int c = 0; c < 6; c++) begin
            case (c)
                0: begin steps = 16;  trig = 1'b1; play = 1'b1; count = 250; end
                1: begin steps = 1;   trig = 1'b1; play = 1'b1; count = 150; end
                2: begin steps = 64;  trig = 1'b0; play = 1'b1; count = 200; end
                3: begin steps = 0;   trig = 1'b1; play = 1'b1; count = 100; end
                4: begin steps = 127; trig = 1'b1; play = 1'b0; count = 60;  end
                default: begin
                    steps = $urandom_range(2, 64); trig = 1'b1; play = 1'b1; count = 320;
                end
            endcase
            wait_drained();
            repeat (4) @(posedge clk);
            configure(steps, trig, play);
            case (c % 4)
                0: begin idle_pct = 0;          stall_pct = 0;          end
                1: begin idle_pct = IDLE_HEAVY; stall_pct = 0;          end
                2: begin idle_pct = 0;          stall_pct = IDLE_HEAVY; end
                default: begin idle_pct = IDLE_LIGHT; stall_pct = IDLE_LIGHT; end
            endcase
            play_random(count);
        end

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (errors == 0) begin
            $display("tb_step_sequencer_track_clock: done, clean");
        end else begin
            $display("tb_step_sequencer_track_clock: done, errors");
        end
        $finish;
    end

endmodule

/* step_sequencer_track_clock.f */
+incdir+rtl/core
rtl/core/sstc_pkg.sv
rtl/core/sstc_ram.sv
rtl/core/sstc_remdiv.sv
rtl/core/step_sequencer_track_clock.sv
rtl/core/sstc_checker.sv
test/track_clock_checker.sv
test/tb_step_sequencer_track_clock.sv
